FILE: rtl/core/sip_pkg.sv
// Package with the types, constants and round functions of the SipHash core.
package sip_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PART_W  = 56;
    localparam int unsigned FILL_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] WIDE_TAG   = 64'h00000000000000ee;
    localparam logic [WORD_W-1:0] SECOND_TAG = 64'h00000000000000dd;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    localparam logic [FILL_W-1:0] FILL_LAST = 3'd7;

    typedef logic [3:0][WORD_W-1:0] t_vstate;

    typedef struct packed {
        logic load_byte;
        logic word_start;
        logic final_start;
        logic half_a;
        logic half_b;
        logic xor_v0_m;
        logic xor_v2_tag;
        logic xor_v1_tag;
        logic cap_lo;
        logic cap_hi;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_full;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] x, int unsigned b);
        return (x << b) | (x >> (WORD_W - b));
    endfunction

    function automatic t_vstate init_state(logic [WORD_W-1:0] k0, logic [WORD_W-1:0] k1);
        t_vstate v;
        v[0] = IV0 ^ k0;
        v[1] = IV1 ^ k1 ^ WIDE_TAG;
        v[2] = IV2 ^ k0;
        v[3] = IV3 ^ k1;
        return v;
    endfunction

    function automatic t_vstate half_round_a(t_vstate v);
        t_vstate r;
        r[0] = v[0] + v[1];
        r[1] = rotl(v[1], 13) ^ r[0];
        r[0] = rotl(r[0], 32);
        r[2] = v[2] + v[3];
        r[3] = rotl(v[3], 16) ^ r[2];
        return r;
    endfunction

    function automatic t_vstate half_round_b(t_vstate v);
        t_vstate r;
        r[0] = v[0] + v[3];
        r[3] = rotl(v[3], 21) ^ r[0];
        r[2] = v[2] + v[1];
        r[1] = rotl(v[1], 17) ^ r[2];
        r[2] = rotl(r[2], 32);
        return r;
    endfunction

endpackage

FILE: rtl/core/sip_ctrl.sv
// Controller state machine that sequences byte intake, rounds and digest output.
module sip_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_cmd,
    input  logic             i_out_ready,
    input  sip_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output sip_pkg::t_dp_cmd o_cmd
);
    import sip_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_CMP_END,
        S_FIN1,
        S_CAP1,
        S_FIN2,
        S_CAP2
    } t_state;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic       r_final;
    logic       r_out_valid;
    logic       w_acc;
    logic       w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load_byte   = !i_cmd && !i_sts.fill_full;
                    o_cmd.word_start  = !i_cmd && i_sts.fill_full;
                    o_cmd.final_start = i_cmd;
                end
            end
            S_CMP, S_FIN1, S_FIN2: begin
                o_cmd.half_a = !r_cnt[0];
                o_cmd.half_b = r_cnt[0];
            end
            S_CMP_END: begin
                o_cmd.xor_v0_m   = 1'b1;
                o_cmd.xor_v2_tag = r_final;
            end
            S_CAP1: begin
                o_cmd.cap_lo     = 1'b1;
                o_cmd.xor_v1_tag = 1'b1;
            end
            S_CAP2: begin
                o_cmd.cap_hi = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CAP2 && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_acc && (i_cmd || i_sts.fill_full)) begin
                        r_final <= i_cmd;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_cnt == 3'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_CMP_END;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_CMP_END: begin
                    r_state <= r_final ? S_FIN1 : S_IDLE;
                end
                S_FIN1: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= S_CAP1;
                    end
                end
                S_CAP1: begin
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= S_CAP2;
                    end
                end
                S_CAP2: begin
                    if (w_out_free) begin
                        r_final <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/sip_dp.sv
// Datapath holding the key, the SipHash state, the byte buffer and the digest registers.
module sip_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sip_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sip_pkg::WORD_W-1:0]        i_cfg_data,
    input  logic [sip_pkg::BYTE_W-1:0]        i_data_byte,
    input  sip_pkg::t_dp_cmd                  i_cmd,
    output sip_pkg::t_dp_sts                  o_sts,
    output logic [sip_pkg::WORD_W-1:0]        o_digest_low,
    output logic [sip_pkg::WORD_W-1:0]        o_digest_high
);
    import sip_pkg::*;

    logic [WORD_W-1:0] r_key_lo, n_key_lo;
    logic [WORD_W-1:0] r_key_hi, n_key_hi;
    t_vstate           r_v, n_v;
    logic [PART_W-1:0] r_part, n_part;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [WORD_W-1:0] r_m, n_m;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_dig_lo;
    logic [WORD_W-1:0] r_dig_hi;
    logic [WORD_W-1:0] w_fold;
    logic [WORD_W-1:0] w_full_word;
    logic [WORD_W-1:0] w_last_word;
    logic              w_key_wr;

    assign o_sts.fill_full = (r_fill == FILL_LAST);
    assign o_digest_low    = r_dig_lo;
    assign o_digest_high   = r_dig_hi;
    assign w_fold          = r_v[0] ^ r_v[1] ^ r_v[2] ^ r_v[3];
    assign w_full_word     = {i_data_byte, r_part};
    assign w_last_word     = {r_len, r_part};
    assign w_key_wr        = i_cfg_we &&
                             (i_cfg_index == REG_KEY_LOW || i_cfg_index == REG_KEY_HIGH);

    always_comb begin
        n_key_lo = r_key_lo;
        n_key_hi = r_key_hi;
        n_v      = r_v;
        n_part   = r_part;
        n_fill   = r_fill;
        n_len    = r_len;
        n_m      = r_m;
        if (i_cfg_we && i_cfg_index == REG_KEY_LOW) begin
            n_key_lo = i_cfg_data;
        end
        if (i_cfg_we && i_cfg_index == REG_KEY_HIGH) begin
            n_key_hi = i_cfg_data;
        end
        if (w_key_wr || i_cmd.cap_hi) begin
            n_v    = init_state(n_key_lo, n_key_hi);
            n_part = '0;
            n_fill = '0;
            n_len  = '0;
        end else begin
            if (i_cmd.load_byte) begin
                n_part = r_part | (PART_W'(i_data_byte) << {r_fill, 3'b000});
                n_fill = r_fill + 3'd1;
                n_len  = r_len + 8'd1;
            end
            if (i_cmd.word_start) begin
                n_v[3] = r_v[3] ^ w_full_word;
                n_m    = w_full_word;
                n_part = '0;
                n_fill = '0;
                n_len  = r_len + 8'd1;
            end
            if (i_cmd.final_start) begin
                n_v[3] = r_v[3] ^ w_last_word;
                n_m    = w_last_word;
            end
            if (i_cmd.half_a) begin
                n_v = half_round_a(r_v);
            end
            if (i_cmd.half_b) begin
                n_v = half_round_b(r_v);
            end
            if (i_cmd.xor_v0_m) begin
                n_v[0] = r_v[0] ^ r_m;
            end
            if (i_cmd.xor_v2_tag) begin
                n_v[2] = r_v[2] ^ WIDE_TAG;
            end
            if (i_cmd.xor_v1_tag) begin
                n_v[1] = r_v[1] ^ SECOND_TAG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_v      <= init_state('0, '0);
            r_part   <= '0;
            r_fill   <= '0;
            r_len    <= '0;
        end else begin
            r_key_lo <= n_key_lo;
            r_key_hi <= n_key_hi;
            r_v      <= n_v;
            r_part   <= n_part;
            r_fill   <= n_fill;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
        if (i_cmd.cap_lo) begin
            r_lo <= w_fold;
        end
        if (i_cmd.cap_hi) begin
            r_dig_lo <= r_lo;
            r_dig_hi <= w_fold;
        end
    end

endmodule

FILE: rtl/core/siphash_2_4_128_stream.sv
// Top level of the keyed SipHash-2-4 stream hasher with a 128-bit digest.
// Each beat on the input carries one message byte or a finalize command. A byte that does
// not complete a 64-bit word is taken without holding off the input; a byte that completes
// a word holds off the input while the shared half-round unit runs the two compression
// rounds as four half rounds followed by the closing xor. A finalize forms the last word,
// runs compression, then two blocks of four finalization rounds, each followed by the
// capture of one digest half; the last capture waits while an earlier digest beat is still
// pending on the output. The key registers may be written only while the block is idle,
// and each write restarts the message from the new key.
module siphash_2_4_128_stream (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sip_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sip_pkg::WORD_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [sip_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sip_pkg::WORD_W-1:0]    o_digest_low,
    output logic [sip_pkg::WORD_W-1:0]    o_digest_high
);
    import sip_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    sip_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_digest_low  (o_digest_low),
        .o_digest_high (o_digest_high)
    );

endmodule

FILE: rtl/core/sip_check.sv
// Port-level checker for the SipHash stream hasher and its bind to the top level.
module sip_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [sip_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [sip_pkg::WORD_W-1:0]    i_cfg_data,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_cmd,
    input logic [sip_pkg::BYTE_W-1:0]    i_data_byte,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [sip_pkg::WORD_W-1:0]    o_digest_low,
    input logic [sip_pkg::WORD_W-1:0]    o_digest_high
);
    logic w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_digest_low) && $stable(o_digest_high))
        else $error("digest beat changed while stalled");

    a_byte_no_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_cmd && !o_out_valid |=> !o_out_valid)
        else $error("byte beat produced a digest");

    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_cmd |=> !o_in_ready)
        else $error("input taken straight after a finalize beat");

    a_final_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_cmd |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("digest appeared too soon after finalize");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind siphash_2_4_128_stream sip_check u_sip_check (.*);

FILE: tb/hash_check_pkg.sv
// Package holding the digest tracker, which predicts and checks the SipHash-2-4-128 digests.
package hash_check_pkg;
    import sip_pkg::*;

    localparam logic CMD_ABSORB   = 1'b0;
    localparam logic CMD_FINALIZE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int COMPRESS_ROUNDS = 2;
    localparam int FINAL_ROUNDS    = 4;

    typedef struct packed {
        logic [WORD_W-1:0] dig_hi;
        logic [WORD_W-1:0] dig_lo;
    } t_digest;

    class digest_tracker;
        bit [WORD_W-1:0] key_lo;
        bit [WORD_W-1:0] key_hi;
        bit [WORD_W-1:0] v [4];
        bit [PART_W-1:0] part;
        bit [FILL_W-1:0] fill;
        bit [BYTE_W-1:0] msg_len;
        t_digest         digests_due [$];
        int              errors;

        function bit [WORD_W-1:0] rot(bit [WORD_W-1:0] x, int n);
            bit [2*WORD_W-1:0] wide;
            wide = {x, x} << n;
            return wide[2*WORD_W-1:WORD_W];
        endfunction

        function void mix_round();
            v[0] += v[1];
            v[1] = rot(v[1], 13) ^ v[0];
            v[0] = rot(v[0], 32);
            v[2] += v[3];
            v[3] = rot(v[3], 16) ^ v[2];
            v[0] += v[3];
            v[3] = rot(v[3], 21) ^ v[0];
            v[2] += v[1];
            v[1] = rot(v[1], 17) ^ v[2];
            v[2] = rot(v[2], 32);
        endfunction

        function void run_rounds(int n);
            for (int r = 0; r < n; r++) begin
                mix_round();
            end
        endfunction

        function void take_word(bit [WORD_W-1:0] m);
            v[3] ^= m;
            run_rounds(COMPRESS_ROUNDS);
            v[0] ^= m;
        endfunction

        function bit [WORD_W-1:0] fold();
            return v[0] ^ v[1] ^ v[2] ^ v[3];
        endfunction

        function void restart();
            v[0]    = IV0 ^ key_lo;
            v[1]    = IV1 ^ key_hi ^ WIDE_TAG;
            v[2]    = IV2 ^ key_lo;
            v[3]    = IV3 ^ key_hi;
            part    = '0;
            fill    = '0;
            msg_len = '0;
        endfunction

        function void reset_model();
            key_lo = '0;
            key_hi = '0;
            restart();
        endfunction

        // A key write throws away any message in progress; other indexes do nothing.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            if (idx == REG_KEY_LOW) begin
                key_lo = val;
            end else if (idx == REG_KEY_HIGH) begin
                key_hi = val;
            end else begin
                return;
            end
            restart();
        endfunction

        function void note_beat(logic cmd, logic [BYTE_W-1:0] b);
            t_digest d;
            if (cmd == CMD_ABSORB) begin
                if (fill == FILL_LAST) begin
                    take_word({b, part});
                    part = '0;
                    fill = '0;
                end else begin
                    part[8*int'(fill) +: 8] = b;
                    fill++;
                end
                msg_len++;
            end else begin
                take_word({msg_len, part});
                v[2] ^= WIDE_TAG;
                run_rounds(FINAL_ROUNDS);
                d.dig_lo = fold();
                v[1] ^= SECOND_TAG;
                run_rounds(FINAL_ROUNDS);
                d.dig_hi = fold();
                digests_due.push_back(d);
                restart();
            end
        endfunction

        function void report(string what);
            errors++;
            $display("mismatch: %s", what);
        endfunction

        function void check_digest(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
            t_digest want;
            if (digests_due.size() == 0) begin
                report($sformatf("digest %h %h arrived with none due", hi, lo));
                return;
            end
            want = digests_due.pop_front();
            if (lo !== want.dig_lo) begin
                report($sformatf("digest_low %h, due %h", lo, want.dig_lo));
            end
            if (hi !== want.dig_hi) begin
                report($sformatf("digest_high %h, due %h", hi, want.dig_hi));
            end
        endfunction

        function int waiting();
            return digests_due.size();
        endfunction
    endclass

endpackage

FILE: tb/tb_top.sv
// Top of the testbench that drives byte and finalize beats into the SipHash stream hasher.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sip_pkg::*;
    import hash_check_pkg::*;

    localparam int TOTAL_ITEMS   = 1350;
    localparam int PHASE_ITEMS   = 220;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 600000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic                 i_cmd       = CMD_ABSORB;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [WORD_W-1:0]    o_digest_low;
    logic [WORD_W-1:0]    o_digest_high;

    digest_tracker tracker;
    int            sent       = 0;
    int            burst_left = 0;
    int            cycles     = 0;
    bit            hold_req   = 1'b0;
    bit            hold_done  = 1'b0;

    siphash_2_4_128_stream uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_digest_low (o_digest_low),
        .o_digest_high(o_digest_high)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_digest(o_digest_low, o_digest_high);
        end
    end

    function automatic logic [WORD_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 64'h5555_aaaa_5555_aaaa;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // The sender works in bursts; a new burst may open with a gap in which valid is low.
    task automatic send_beat(input logic cmd, input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_beat(cmd, b);
        sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    // Waits until every digest due has arrived, then lets the last word absorb finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : out_side
        int pat;
        int span;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            pat  = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                case (pat)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ~i_out_ready;
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : in_side
        int         len;
        int         phase_start;
        logic [1:0] which;
        tracker = new();
        tracker.reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message, a short one with extreme bytes, and exactly one full word.
        send_beat(CMD_FINALIZE, 8'h00);
        send_beat(CMD_ABSORB, 8'h00);
        send_beat(CMD_ABSORB, 8'hff);
        send_beat(CMD_FINALIZE, 8'hff);
        for (int k = 0; k < 8; k++) begin
            send_beat(CMD_ABSORB, 8'h01 << k);
        end
        send_beat(CMD_FINALIZE, 8'h00);
        drain();

        cfg_write(REG_KEY_LOW, '1);
        cfg_write(REG_KEY_HIGH, '1);
        cfg_write(REG_SPARE_2, 64'h0123_4567_89ab_cdef);
        cfg_write(REG_SPARE_3, '1);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 7; k++) begin
            send_beat(CMD_ABSORB, 8'hfe >> k);
        end
        send_beat(CMD_FINALIZE, 8'h5a);

        // A key write in the middle of a message starts it afresh.
        send_beat(CMD_ABSORB, 8'h80);
        send_beat(CMD_ABSORB, 8'h7f);
        send_beat(CMD_ABSORB, 8'h01);
        drain();
        cfg_write(REG_KEY_LOW, 64'h0f1e_2d3c_4b5a_6978);
        i_cfg_we <= 1'b0;
        send_beat(CMD_FINALIZE, 8'h00);
        drain();

        hold_req = 1'b1;
        while (sent < TOTAL_ITEMS) begin
            which = 2'($urandom_range(0, 3));
            if (which != 2'd1) begin
                cfg_write(REG_KEY_LOW, pick_key());
            end
            if (which != 2'd0) begin
                cfg_write(REG_KEY_HIGH, pick_key());
            end
            if (which == 2'd3) begin
                cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
            end
            i_cfg_we <= 1'b0;

            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS && sent < TOTAL_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 300)
                                                  : $urandom_range(0, 24);
                repeat (len) send_beat(CMD_ABSORB, 8'($urandom));
                if (sent - phase_start < PHASE_ITEMS || $urandom_range(0, 2) != 0) begin
                    send_beat(CMD_FINALIZE, 8'($urandom));
                end
            end
            drain();
        end

        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sip_pkg.sv
rtl/core/sip_ctrl.sv
rtl/core/sip_dp.sv
rtl/core/siphash_2_4_128_stream.sv
rtl/core/sip_check.sv
tb/hash_check_pkg.sv
tb/tb_top.sv
